// ===== sv/fpcc_pkg.sv =====
// fpcc_pkg: shared constants and types for the first-person camera block
package fpcc_pkg;

	localparam int AngFull  = 92160;
	localparam int AngQuart = 23040;

	localparam logic [16:0] YAW_RST   = 17'd69120;
	localparam logic [15:0] SENS_RST  = 16'd3277;
	localparam logic [15:0] SPEED_RST = 16'd1280;
	localparam logic [14:0] LIM_RST   = 15'd22784;

	localparam logic [1:0] CFG_SENS  = 2'd0;
	localparam logic [1:0] CFG_SPEED = 2'd1;
	localparam logic [1:0] CFG_LIM   = 2'd2;

	localparam logic signed [31:0] C1 = 32'sd1686629713;
	localparam logic signed [31:0] C3 = 32'sd693598669;
	localparam logic signed [31:0] C5 = 32'sd85569306;
	localparam logic signed [31:0] C7 = 32'sd5026993;
	localparam logic signed [31:0] C9 = 32'sd172273;

	typedef struct packed {
		logic        go;
		logic [16:0] angle;
	} sc_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] value;
	} sc_rsp_t;

endpackage

// ===== sv/first_person_camera_control.sv =====
// first_person_camera_control: top level with config registers, handshakes and result register
//  channel  | signals                                   | dir
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | in
//  in       | in_valid in_ready func pointer_* frame_*  | in
//  out      | out_valid out_ready pos_* front_*         | out
// a pointer event runs a serial yaw wrap, then four sine evaluations, each
// a serial division plus six multiply steps
// a frame tick runs two sine evaluations then six mac steps
// reset (arst_n low) restores the camera state and registers at once
// in_ready stays low until the waiting result has been taken
module first_person_camera_control import fpcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic signed [15:0] pointer_x,
	input  logic signed [15:0] pointer_y,
	input  logic [31:0]        frame_time,
	input  logic [3:0]         move_keys,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z
);

	logic [15:0]        sens_q;
	logic [15:0]        speed_q;
	logic [14:0]        lim_q;
	logic               busy_q;
	logic               ov_q;
	sc_req_t            sc_req;
	sc_rsp_t            sc_rsp;
	logic               finish;
	logic signed [31:0] px;
	logic signed [31:0] py;
	logic signed [31:0] pz;
	logic signed [15:0] fx;
	logic signed [15:0] fy;
	logic signed [15:0] fz;
	logic               start;

	assign cfg_ready = 1'b1;
	assign in_ready  = !busy_q && !ov_q;
	assign start     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q  <= SENS_RST;
			speed_q <= SPEED_RST;
			lim_q   <= LIM_RST;
			busy_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SENS:  sens_q  <= cfg_data;
					CFG_SPEED: speed_q <= cfg_data;
					CFG_LIM:   lim_q   <= cfg_data[14:0];
					default: ;
				endcase
			end
			// busy until result lands in a free output register
			if (start)
				busy_q <= 1'b1;
			else if (finish)
				busy_q <= 1'b0;
			if (finish)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			pos_x   <= px;
			pos_y   <= py;
			pos_z   <= pz;
			front_x <= fx;
			front_y <= fy;
			front_z <= fz;
		end
	end

	assign out_valid = ov_q;

	fpcc_sincos u_sincos (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sc_req),
		.rsp    (sc_rsp)
	);

	fpcc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.pointer_x  (pointer_x),
		.pointer_y  (pointer_y),
		.frame_time (frame_time),
		.move_keys  (move_keys),
		.sens       (sens_q),
		.speed      (speed_q),
		.lim_reg    (lim_q),
		.sc_req     (sc_req),
		.sc_rsp     (sc_rsp),
		.finish     (finish),
		.pos_x      (px),
		.pos_y      (py),
		.pos_z      (pz),
		.front_x    (fx),
		.front_y    (fy),
		.front_z    (fz)
	);

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready) else $error("item taken while busy");
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> busy_q) else $error("result without item");
	a_out_set: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid) else $error("result lost");
`endif

endmodule

// ===== sv/fpcc_sincos.sv =====
// fpcc_sincos: sequential quarter-wave sine unit, one multiply per cycle
module fpcc_sincos import fpcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  sc_req_t req,
	output sc_rsp_t rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SQ   = 3'd2;
	localparam logic [2:0] ST_POLY = 3'd3;
	localparam logic [2:0] ST_LAST = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]         state_q;
	logic [1:0]         quad_q;
	logic [30:0]        rem_q;
	logic [30:0]        t_q;
	logic [4:0]         cnt_q;
	logic signed [31:0] u_q;
	logic signed [31:0] p_q;
	logic signed [15:0] res_q;

	logic [16:0]        a_mod;
	logic [1:0]         q_c;
	logic [14:0]        r_c;
	logic [14:0]        r_fold;
	logic signed [63:0] prod;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [31:0] m30;
	logic signed [31:0] coef;
	logic signed [31:0] s_r;
	logic signed [15:0] s_cl;
	logic [31:0]        rem_sh;

	always_comb begin
		a_mod = req.angle;
		if (a_mod >= 17'(AngQuart * 3)) begin
			q_c = 2'd3;
			r_c = 15'(a_mod - 17'(AngQuart * 3));
		end else if (a_mod >= 17'(AngQuart * 2)) begin
			q_c = 2'd2;
			r_c = 15'(a_mod - 17'(AngQuart * 2));
		end else if (a_mod >= 17'(AngQuart)) begin
			q_c = 2'd1;
			r_c = 15'(a_mod - 17'(AngQuart));
		end else begin
			q_c = 2'd0;
			r_c = a_mod[14:0];
		end
		r_fold = q_c[0] ? 15'(15'(AngQuart) - r_c) : r_c;
	end

	always_comb begin
		unique case (state_q)
			ST_SQ: begin
				mul_a = $signed({1'b0, t_q});
				mul_b = $signed({1'b0, t_q});
			end
			ST_LAST: begin
				mul_a = p_q;
				mul_b = $signed({1'b0, t_q});
			end
			default: begin
				mul_a = p_q;
				mul_b = u_q;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
		// truncate toward zero
		m30 = 32'((prod + (prod[63] ? 64'sd1073741823 : 64'sd0)) >>> 30);
		unique case (cnt_q[2:0])
			3'd0:    coef = -C7;
			3'd1:    coef = C5;
			3'd2:    coef = -C3;
			default: coef = C1;
		endcase
		s_r = (m30 + 32'sd32768) >>> 16;
		if (s_r < 0)
			s_cl = 16'sd0;
		else if (s_r > 32'sd16384)
			s_cl = 16'sd16384;
		else
			s_cl = 16'(s_r);
		rem_sh = {rem_q, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (req.go) begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == 5'd30) state_q <= ST_SQ;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_SQ: begin
					state_q <= ST_POLY;
					cnt_q   <= '0;
				end
				ST_POLY: begin
					if (cnt_q == 5'd3) state_q <= ST_LAST;
					cnt_q <= cnt_q + 5'd1;
				end
				ST_LAST: state_q <= ST_DONE;
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// restoring division of r * 2^30 by 23040, one quotient bit a cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				quad_q <= q_c;
				rem_q  <= 31'(r_fold);
				t_q    <= '0;
			end
			ST_DIV: begin
				if (cnt_q == 5'd0) begin
					// r <= 23040: r / 23040 gives leading quotient bit
					if (rem_q >= 31'(AngQuart)) begin
						t_q   <= 31'd1;
						rem_q <= rem_q - 31'(AngQuart);
					end else begin
						t_q <= '0;
					end
				end else if (rem_sh >= 32'(AngQuart)) begin
					t_q   <= {t_q[29:0], 1'b1};
					rem_q <= 31'(rem_sh - 32'(AngQuart));
				end else begin
					t_q   <= {t_q[29:0], 1'b0};
					rem_q <= 31'(rem_sh);
				end
			end
			ST_SQ: begin
				u_q <= m30;
				p_q <= C9;
			end
			ST_POLY: p_q <= coef + m30;
			ST_LAST: res_q <= quad_q[1] ? -s_cl : s_cl;
			default: ;
		endcase
	end

	assign rsp.done  = (state_q == ST_DONE);
	assign rsp.value = res_q;

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("done held");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (rsp.value <= 16'sd16384 && rsp.value >= -16'sd16384))
		else $error("sine out of range");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LAST) |=> (state_q == ST_DONE)) else $error("sequence slip");
`endif

endmodule

// ===== sv/fpcc_ctrl.sv =====
// fpcc_ctrl: item sequencer holding camera state, using a shared sine unit and serial mac
module fpcc_ctrl import fpcc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               func,
	input  logic signed [15:0] pointer_x,
	input  logic signed [15:0] pointer_y,
	input  logic [31:0]        frame_time,
	input  logic [3:0]         move_keys,
	input  logic [15:0]        sens,
	input  logic [15:0]        speed,
	input  logic [14:0]        lim_reg,
	output sc_req_t            sc_req,
	input  sc_rsp_t            sc_rsp,
	output logic               finish,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ANG  = 4'd1;
	localparam logic [3:0] ST_SIN  = 4'd2;
	localparam logic [3:0] ST_WAIT = 4'd3;
	localparam logic [3:0] ST_FV   = 4'd4;
	localparam logic [3:0] ST_K    = 4'd5;
	localparam logic [3:0] ST_MV   = 4'd6;
	localparam logic [3:0] ST_ADD  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;
	localparam logic [3:0] ST_RED  = 4'd9;

	logic [3:0]         state_q;
	logic [16:0]        yaw_q;
	logic signed [15:0] pitch_q;
	logic signed [15:0] lpx_q;
	logic signed [15:0] lpy_q;
	logic               first_q;
	logic [31:0]        lft_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] fv_q [3];
	logic signed [15:0] trig_q [4];
	logic [1:0]         tidx_q;
	logic               func_q;
	logic [3:0]         keys_q;
	logic [47:0]        k_q;
	logic [1:0]         ax_q;
	logic               half_q;
	logic signed [42:0] sum_q;
	logic signed [16:0] dxs_q;
	logic signed [16:0] dys_q;
	logic [26:0]        acc_q;
	logic [26:0]        mod_q;
	logic [3:0]         red_q;

	logic signed [33:0] dxp;
	logic signed [33:0] dyp;
	logic signed [25:0] dx;
	logic signed [25:0] dy;
	logic signed [26:0] ynew;
	logic [26:0]        red_v;
	logic signed [26:0] pnew;
	logic signed [15:0] lim;
	logic signed [15:0] pclamp;
	logic [16:0]        sc_ang;
	logic [16:0]        pang;
	logic signed [31:0] fxp;
	logic signed [31:0] fzp;
	logic signed [15:0] comp;
	logic signed [64:0] mv;
	logic signed [41:0] mvr;
	logic signed [43:0] psum;
	logic signed [31:0] psat;
	logic signed [15:0] rv;
	logic [31:0]        dt;

	always_comb begin
		dxp  = 34'(dxs_q) * $signed({1'b0, sens});
		dyp  = 34'(dys_q) * $signed({1'b0, sens});
		dx   = 26'((dxp + 34'sd128) >>> 8);
		dy   = 26'((dyp + 34'sd128) >>> 8);
		ynew = 27'($signed({1'b0, yaw_q})) + 27'(dx);
		// one compare and subtract step of the yaw wrap
		red_v = (acc_q >= mod_q) ? 27'(acc_q - mod_q) : acc_q;
		lim  = (lim_reg > 15'(AngQuart)) ? 16'(AngQuart) : $signed({1'b0, lim_reg});
		pnew = 27'(pitch_q) + 27'(dy);
		if (pnew > 27'(lim))
			pclamp = lim;
		else if (pnew < -27'(lim))
			pclamp = -lim;
		else
			pclamp = 16'(pnew);
		pang = pitch_q[15] ? 17'(18'(pitch_q) + 18'(AngFull)) : 17'(pitch_q);
		case (tidx_q)
			2'd0:    sc_ang = yaw_q;
			2'd1:    sc_ang = (yaw_q >= 17'(AngFull - AngQuart)) ?
				17'(yaw_q - 17'(AngFull - AngQuart)) : 17'(yaw_q + 17'(AngQuart));
			2'd2:    sc_ang = pang;
			default: sc_ang = (pang >= 17'(AngFull - AngQuart)) ?
				17'(pang - 17'(AngFull - AngQuart)) : 17'(pang + 17'(AngQuart));
		endcase
		fxp = 32'(trig_q[1]) * 32'(trig_q[3]);
		fzp = 32'(trig_q[0]) * 32'(trig_q[3]);
		comp = fv_q[ax_q];
		case (ax_q)
			2'd0:    rv = -trig_q[0];
			2'd2:    rv = trig_q[1];
			default: rv = 16'sd0;
		endcase
		if (half_q) comp = rv;
		mv   = 65'($signed({1'b0, k_q})) * 65'(comp);
		mvr  = 42'((mv + 65'sd2097152) >>> 22);
		psum = 44'(pos_q[ax_q]) + 44'(sum_q);
		if (psum > 44'sd2147483647)
			psat = 32'sh7fffffff;
		else if (psum < -44'sd2147483648)
			psat = 32'sh80000000;
		else
			psat = 32'(psum);
		dt = frame_time - lft_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			yaw_q    <= YAW_RST;
			pitch_q  <= '0;
			lpx_q    <= 16'sd600;
			lpy_q    <= 16'sd400;
			first_q  <= 1'b1;
			lft_q    <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= 32'sd196608;
			fv_q[0]  <= '0;
			fv_q[1]  <= '0;
			fv_q[2]  <= -16'sd16384;
			tidx_q   <= '0;
			ax_q     <= '0;
			half_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) begin
					func_q <= func;
					keys_q <= move_keys;
					tidx_q <= '0;
					if (func) begin
						k_q   <= 48'(speed) * 48'(dt);
						lft_q <= frame_time;
					end else begin
						dxs_q <= first_q ? 17'sd0 : 17'(pointer_x) - 17'(lpx_q);
						dys_q <= first_q ? 17'sd0 : 17'(lpy_q) - 17'(pointer_y);
						lpx_q <= pointer_x;
						lpy_q <= pointer_y;
						first_q <= 1'b0;
					end
					state_q <= func ? ST_SIN : ST_ANG;
				end
				ST_ANG: begin
					pitch_q <= pclamp;
					// bias negative sums by 256 turns, then reduce serially
					acc_q   <= (ynew < 0) ? 27'(ynew + 27'(AngFull * 256)) : 27'(ynew);
					mod_q   <= 27'(AngFull * 256);
					red_q   <= 4'd8;
					state_q <= ST_RED;
				end
				ST_RED: begin
					acc_q <= red_v;
					mod_q <= mod_q >> 1;
					if (red_q == 4'd0) begin
						yaw_q   <= 17'(red_v);
						state_q <= ST_SIN;
					end else begin
						red_q <= red_q - 4'd1;
					end
				end
				ST_SIN: state_q <= ST_WAIT;
				ST_WAIT: if (sc_rsp.done) begin
					trig_q[tidx_q] <= sc_rsp.value;
					tidx_q <= tidx_q + 2'd1;
					if (func_q && tidx_q == 2'd1) begin
						state_q <= ST_MV;
						ax_q    <= '0;
						half_q  <= 1'b0;
						sum_q   <= '0;
					end else if (tidx_q == 2'd3) begin
						state_q <= ST_FV;
					end else begin
						state_q <= ST_SIN;
					end
				end
				ST_FV: begin
					fv_q[0] <= 16'((fxp + 32'sd8192) >>> 14);
					fv_q[1] <= trig_q[2];
					fv_q[2] <= 16'((fzp + 32'sd8192) >>> 14);
					state_q <= ST_FIN;
				end
				ST_MV: begin
					if (!half_q) begin
						sum_q <= (keys_q[0] ? 43'(mvr) : 43'sd0) -
							(keys_q[1] ? 43'(mvr) : 43'sd0);
						half_q <= 1'b1;
					end else begin
						sum_q <= sum_q + (keys_q[3] ? 43'(mvr) : 43'sd0) -
							(keys_q[2] ? 43'(mvr) : 43'sd0);
						half_q  <= 1'b0;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					pos_q[ax_q] <= psat;
					sum_q <= '0;
					if (ax_q == 2'd2) begin
						state_q <= ST_FIN;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_MV;
					end
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sc_req.go    = (state_q == ST_SIN);
	assign sc_req.angle = sc_ang;
	assign finish  = (state_q == ST_FIN);
	assign pos_x   = pos_q[0];
	assign pos_y   = pos_q[1];
	assign pos_z   = pos_q[2];
	assign front_x = fv_q[0];
	assign front_y = fv_q[1];
	assign front_z = fv_q[2];

`ifndef SYNTHESIS
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		yaw_q < 17'(AngFull)) else $error("yaw out of range");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pitch_q <= 16'sd23040 && pitch_q >= -16'sd23040)) else $error("pitch out of range");
	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> !finish) else $error("finish held");
`endif

endmodule
